@@ rtl/prc_pkg.sv @@
`timescale 1ns / 1ps

package prc_pkg;

   localparam int TIME_W      = 32;
   localparam int ECHO_W      = 20;
   localparam int DIST_W      = 15;
   localparam int DISTCFG_W   = 12;
   localparam int DELAY_W     = 16;
   localparam int YEAR_W      = 8;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int OUT_COUNT_W = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Width of the lift counters; the result carries their low 32 bits.
   localparam int COUNT_WIDTH = 32;

   // Echo to cm: echo / 58 == (echo >> 1) / 29, done as a multiply by a
   // rounded-up reciprocal of 29 scaled by 2^24. The rounding error of 9
   // stays below 2^(24 - 19), so the quotient is exact for any 19-bit value.
   localparam int HALF_ECHO_W  = ECHO_W - 1;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_W      = 20;
   localparam logic [RECIP_W-1:0] RECIP_29 = 20'd578525;
   localparam int PROD_W       = HALF_ECHO_W + RECIP_W;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_DATE   = 1'b1;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_LIMIT       = 3'd0,
      CSR_LIFT_LIMIT       = 3'd1,
      CSR_ON_DELAY         = 3'd2,
      CSR_OFF_DELAY        = 3'd3,
      CSR_DWELL_TIME       = 3'd4,
      CSR_REFRACTORY_TIME  = 3'd5,
      CSR_SAMPLE_INTERVAL  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DISTCFG_W-1:0] near_limit;
      logic [DISTCFG_W-1:0] lift_limit;
      logic [DELAY_W-1:0]   backlight_on_delay;
      logic [DELAY_W-1:0]   backlight_off_delay;
      logic [DELAY_W-1:0]   dwell_time;
      logic [DELAY_W-1:0]   refractory_time;
      logic [DELAY_W-1:0]   sample_interval;
   } cfg_type;

   typedef struct packed {
      logic               req_type;
      logic [TIME_W-1:0]  now_ms;
      logic [DIST_W-1:0]  range_cm;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } item_type;

   typedef struct packed {
      logic                   backlight_on;
      logic                   counted;
      logic [OUT_COUNT_W-1:0] all_count;
      logic [OUT_COUNT_W-1:0] day_count;
   } result_type;

   function automatic logic [DIST_W-1:0] echo_to_cm(input logic [ECHO_W-1:0] echo);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(echo[ECHO_W-1:1]) * PROD_W'(RECIP_29);
      return prod[RECIP_SHIFT +: DIST_W];
   endfunction

endpackage

@@ rtl/prc_if.sv @@
`timescale 1ns / 1ps

interface prc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [prc_pkg::TIME_W-1:0]      now_ms;
   logic [prc_pkg::ECHO_W-1:0]      echo_us;
   logic [prc_pkg::YEAR_W-1:0]      year;
   logic [prc_pkg::MONTH_W-1:0]     month;
   logic [prc_pkg::DAY_W-1:0]       day;

   modport source (output valid, req_type, now_ms, echo_us, year, month, day, input ready);
   modport sink   (input valid, req_type, now_ms, echo_us, year, month, day, output ready);
endinterface

interface prc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              backlight_on;
   logic                              counted;
   logic [prc_pkg::OUT_COUNT_W-1:0]   all_count;
   logic [prc_pkg::OUT_COUNT_W-1:0]   day_count;

   modport source (output valid, backlight_on, counted, all_count, day_count, input ready);
   modport sink   (input valid, backlight_on, counted, all_count, day_count, output ready);
endinterface

interface prc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [prc_pkg::CSR_IDX_W-1:0]    index;
   logic [prc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/proximity_rep_counter.sv @@
`timescale 1ns / 1ps

// Lift counter driven by ultrasonic echo samples and calendar date checks.
// req_ch takes one beat per item: req_type selects a distance sample (echo_us)
// or a date check (year, month, day); now_ms is the item's millisecond time.
// rsp_ch returns exactly one beat per item, in order: the backlight flag,
// whether this item counted a lift, and the total and daily lift counts.
// csr_ch writes the seven threshold and timing registers by index; it is
// always ready, and the user must write it only while the block is idle;
// the block does not enforce this. A request beat passes the input register
// and then the response register; the echo is converted to cm while the
// beat is registered, and all state is updated in one pass between the two
// registers. One item per cycle is sustained while rsp_ch is ready.
// When rsp_ch stalls, the response register holds and one more request is
// still taken into the input register; req_ch.ready drops after that.
// Reset clears both pipeline valid flags, restores the register defaults,
// zeroes all times and counts, and turns the backlight flag on.
module proximity_rep_counter (
   input logic      clock,
   input logic      reset,
   prc_req_if.sink  req_ch,
   prc_rsp_if.source rsp_ch,
   prc_csr_if.sink  csr_ch
);

   prc_pkg::cfg_type    cfg;
   prc_pkg::item_type   item_ff, item_in;
   logic                item_valid_ff, item_valid_in;
   prc_pkg::result_type result;
   prc_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_beat, advance;

   assign csr_ch.ready = 1'b1;

   prc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;
   assign req_beat     = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.req_type = req_ch.req_type;
      item_in.now_ms   = req_ch.now_ms;
      item_in.range_cm = prc_pkg::echo_to_cm(req_ch.echo_us);
      item_in.year     = req_ch.year;
      item_in.month    = req_ch.month;
      item_in.day      = req_ch.day;

      item_valid_in = req_beat || (item_valid_ff && !advance);

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   prc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (item_ff),
      .result (result)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.backlight_on = rsp_ff.backlight_on;
   assign rsp_ch.counted      = rsp_ff.counted;
   assign rsp_ch.all_count    = rsp_ff.all_count;
   assign rsp_ch.day_count    = rsp_ff.day_count;

endmodule

@@ rtl/prc_csr.sv @@
`timescale 1ns / 1ps

module prc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [prc_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [prc_pkg::CSR_DATA_W-1:0]   wr_data,
   output prc_pkg::cfg_type                 cfg
);

   prc_pkg::cfg_type cfg_ff;
   prc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (prc_pkg::csr_index_type'(wr_index))
            prc_pkg::CSR_NEAR_LIMIT:
               cfg_in.near_limit = wr_data[prc_pkg::DISTCFG_W-1:0];
            prc_pkg::CSR_LIFT_LIMIT:
               cfg_in.lift_limit = wr_data[prc_pkg::DISTCFG_W-1:0];
            prc_pkg::CSR_ON_DELAY:        cfg_in.backlight_on_delay  = wr_data;
            prc_pkg::CSR_OFF_DELAY:       cfg_in.backlight_off_delay = wr_data;
            prc_pkg::CSR_DWELL_TIME:      cfg_in.dwell_time          = wr_data;
            prc_pkg::CSR_REFRACTORY_TIME: cfg_in.refractory_time     = wr_data;
            prc_pkg::CSR_SAMPLE_INTERVAL: cfg_in.sample_interval     = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit          <= 12'd100;
         cfg_ff.lift_limit          <= 12'd30;
         cfg_ff.backlight_on_delay  <= 16'd500;
         cfg_ff.backlight_off_delay <= 16'd10000;
         cfg_ff.dwell_time          <= 16'd1000;
         cfg_ff.refractory_time     <= 16'd2000;
         cfg_ff.sample_interval     <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/prc_core.sv @@
`timescale 1ns / 1ps

module prc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  prc_pkg::cfg_type     cfg,
   input  logic                 step,
   input  prc_pkg::item_type    item,
   output prc_pkg::result_type  result
);

   logic [prc_pkg::TIME_W-1:0]  last_sample_ff, last_sample_in;
   logic [prc_pkg::TIME_W-1:0]  last_near_ff, last_near_in;
   logic [prc_pkg::TIME_W-1:0]  last_empty_ff, last_empty_in;
   logic [prc_pkg::TIME_W-1:0]  last_count_ff, last_count_in;
   logic [prc_pkg::TIME_W-1:0]  lift_start_ff, lift_start_in;
   logic                        lift_counted_ff, lift_counted_in;
   logic                        backlight_ff, backlight_in;
   prc_pkg::count_type          total_ff, total_in;
   prc_pkg::count_type          daily_ff, daily_in;
   logic [prc_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [prc_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [prc_pkg::DAY_W-1:0]   day_ff, day_in;

   logic [prc_pkg::TIME_W-1:0]  now;
   logic [prc_pkg::TIME_W-1:0]  sample_t, near_t, empty_t, count_t;
   logic [prc_pkg::TIME_W-1:0]  due_t, start_t;
   logic [prc_pkg::TIME_W-1:0]  since_empty, since_near, since_start, since_count;
   logic [prc_pkg::DIST_W-1:0]  empty_d, lifting_d;
   logic                        is_date, date_differs, sample_ok, counted;

   assign now     = item.now_ms;
   assign is_date = (item.req_type == prc_pkg::REQ_DATE);

   // Stored times past now mean the timer wrapped; pull them back first.
   assign sample_t = (last_sample_ff > now) ? now : last_sample_ff;
   assign near_t   = (last_near_ff > now) ? now : last_near_ff;
   assign empty_t  = (last_empty_ff > now) ? now : last_empty_ff;
   assign count_t  = (last_count_ff > now) ? now : last_count_ff;

   assign due_t     = sample_t + prc_pkg::TIME_W'(cfg.sample_interval);
   assign sample_ok = !is_date && (now > due_t);

   assign empty_d   = prc_pkg::DIST_W'(cfg.near_limit);
   assign lifting_d = prc_pkg::DIST_W'(cfg.lift_limit);

   // A zero start time marks no lift in progress.
   assign start_t     = (lift_start_ff == '0) ? now : lift_start_ff;
   assign since_empty = now - empty_t;
   assign since_near  = now - near_t;
   assign since_start = now - start_t;
   assign since_count = now - count_t;

   assign date_differs = (item.year != year_ff) || (item.month != month_ff) ||
                         (item.day != day_ff);

   always_comb begin
      last_sample_in  = sample_t;
      last_near_in    = near_t;
      last_empty_in   = empty_t;
      last_count_in   = count_t;
      lift_start_in   = lift_start_ff;
      lift_counted_in = lift_counted_ff;
      backlight_in    = backlight_ff;
      total_in        = total_ff;
      daily_in        = daily_ff;
      year_in         = year_ff;
      month_in        = month_ff;
      day_in          = day_ff;
      counted         = 1'b0;

      if (is_date) begin
         if (date_differs) begin
            daily_in = '0;
            year_in  = item.year;
            month_in = item.month;
            day_in   = item.day;
         end
      end else if (sample_ok) begin
         if (item.range_cm < empty_d) begin
            if (since_empty > prc_pkg::TIME_W'(cfg.backlight_on_delay)) begin
               backlight_in = 1'b1;
            end
            last_near_in = now;
         end
         if (item.range_cm > empty_d) begin
            if (since_near > prc_pkg::TIME_W'(cfg.backlight_off_delay)) begin
               backlight_in = 1'b0;
            end
            last_empty_in = now;
         end
         if (item.range_cm < lifting_d) begin
            lift_start_in = start_t;
            if ((since_start > prc_pkg::TIME_W'(cfg.dwell_time)) && !lift_counted_ff &&
                (since_count > prc_pkg::TIME_W'(cfg.refractory_time))) begin
               total_in        = total_ff + prc_pkg::count_type'(1);
               daily_in        = daily_ff + prc_pkg::count_type'(1);
               lift_counted_in = 1'b1;
               last_count_in   = now;
               counted         = 1'b1;
            end
         end
         if (item.range_cm > lifting_d) begin
            lift_counted_in = 1'b0;
            lift_start_in   = '0;
         end
         last_sample_in = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff  <= '0;
         last_near_ff    <= '0;
         last_empty_ff   <= '0;
         last_count_ff   <= '0;
         lift_start_ff   <= '0;
         lift_counted_ff <= 1'b0;
         backlight_ff    <= 1'b1;
         total_ff        <= '0;
         daily_ff        <= '0;
         year_ff         <= '0;
         month_ff        <= '0;
         day_ff          <= '0;
      end else if (step) begin
         last_sample_ff  <= last_sample_in;
         last_near_ff    <= last_near_in;
         last_empty_ff   <= last_empty_in;
         last_count_ff   <= last_count_in;
         lift_start_ff   <= lift_start_in;
         lift_counted_ff <= lift_counted_in;
         backlight_ff    <= backlight_in;
         total_ff        <= total_in;
         daily_ff        <= daily_in;
         year_ff         <= year_in;
         month_ff        <= month_in;
         day_ff          <= day_in;
      end
   end

   assign result.backlight_on = backlight_in;
   assign result.counted      = counted;
   assign result.all_count    = prc_pkg::OUT_COUNT_W'(total_in);
   assign result.day_count    = prc_pkg::OUT_COUNT_W'(daily_in);

   a_count_arms_lock: assert property (@(posedge clock) disable iff (reset)
      step && counted |=> lift_counted_ff)
      else $error("counted lift did not set the lift lock");

   a_lock_bumps_total: assert property (@(posedge clock) disable iff (reset)
      $rose(lift_counted_ff) |-> total_ff == $past(total_ff) + prc_pkg::count_type'(1))
      else $error("lift lock set without a total count increment");

   a_new_date_clears: assert property (@(posedge clock) disable iff (reset)
      step && is_date && date_differs |=> daily_ff == '0)
      else $error("new date did not clear the day count");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(total_ff) && $stable(daily_ff) && $stable(backlight_ff))
      else $error("state changed without a processed item");

endmodule

@@ sim/tb_proximity_rep_counter.sv @@
`timescale 1ns / 1ps

module tb_proximity_rep_counter;

   localparam int CYCLE_LIMIT = 300000;
   localparam logic [prc_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef struct packed {
      logic                        req_type;
      logic [prc_pkg::TIME_W-1:0]  now_ms;
      logic [prc_pkg::ECHO_W-1:0]  echo_us;
      logic [prc_pkg::YEAR_W-1:0]  year;
      logic [prc_pkg::MONTH_W-1:0] month;
      logic [prc_pkg::DAY_W-1:0]   day;
   } sensor_beat_type;

   logic clock;
   logic reset;

   prc_req_if req_ch();
   prc_rsp_if rsp_ch();
   prc_csr_if csr_ch();

   proximity_rep_counter uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sensor_beat_type     pending_beats[$];
   prc_pkg::result_type expected_results[$];
   sensor_beat_type     held_beat;
   int                  send_gap;
   int                  stall_left;
   int                  mismatch_count;
   logic                idling_on;

   // Predictor copy of the block's registers and state.
   prc_pkg::cfg_type            lift_cfg;
   logic [prc_pkg::TIME_W-1:0]  last_sample_ms;
   logic [prc_pkg::TIME_W-1:0]  last_near_ms;
   logic [prc_pkg::TIME_W-1:0]  last_empty_ms;
   logic [prc_pkg::TIME_W-1:0]  last_count_ms;
   logic [prc_pkg::TIME_W-1:0]  lift_start_ms;
   logic                        lift_done;
   logic                        backlight_flag;
   prc_pkg::count_type          total_lifts;
   prc_pkg::count_type          daily_lifts;
   logic [prc_pkg::YEAR_W-1:0]  date_year;
   logic [prc_pkg::MONTH_W-1:0] date_month;
   logic [prc_pkg::DAY_W-1:0]   date_day;

   // Stimulus planning: the time line and the date used by generated items.
   logic [prc_pkg::TIME_W-1:0]  plan_ms;
   logic [prc_pkg::YEAR_W-1:0]  plan_year;
   logic [prc_pkg::MONTH_W-1:0] plan_month;
   logic [prc_pkg::DAY_W-1:0]   plan_day;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic prc_pkg::result_type predict_lift_result(input sensor_beat_type b);
      prc_pkg::result_type r;
      logic [31:0] dist_cm;
      r = '0;
      // Any stored time ahead of now is taken as a timer wrap.
      if (last_sample_ms > b.now_ms) last_sample_ms = b.now_ms;
      if (last_near_ms > b.now_ms) last_near_ms = b.now_ms;
      if (last_empty_ms > b.now_ms) last_empty_ms = b.now_ms;
      if (last_count_ms > b.now_ms) last_count_ms = b.now_ms;
      if (b.req_type == prc_pkg::REQ_DATE) begin
         if (b.year != date_year || b.month != date_month || b.day != date_day) begin
            daily_lifts = '0;
            date_year   = b.year;
            date_month  = b.month;
            date_day    = b.day;
         end
      end else if (b.now_ms > last_sample_ms + lift_cfg.sample_interval) begin
         dist_cm = 32'(b.echo_us) / 32'd58;
         if (dist_cm < lift_cfg.near_limit) begin
            if (b.now_ms - last_empty_ms > lift_cfg.backlight_on_delay) backlight_flag = 1'b1;
            last_near_ms = b.now_ms;
         end
         if (dist_cm > lift_cfg.near_limit) begin
            if (b.now_ms - last_near_ms > lift_cfg.backlight_off_delay) backlight_flag = 1'b0;
            last_empty_ms = b.now_ms;
         end
         if (dist_cm < lift_cfg.lift_limit) begin
            if (lift_start_ms == '0) lift_start_ms = b.now_ms;
            if (b.now_ms - lift_start_ms > lift_cfg.dwell_time && !lift_done &&
                b.now_ms - last_count_ms > lift_cfg.refractory_time) begin
               total_lifts   = total_lifts + 1'b1;
               daily_lifts   = daily_lifts + 1'b1;
               lift_done     = 1'b1;
               last_count_ms = b.now_ms;
               r.counted     = 1'b1;
            end
         end
         if (dist_cm > lift_cfg.lift_limit) begin
            lift_done     = 1'b0;
            lift_start_ms = '0;
         end
         last_sample_ms = b.now_ms;
      end
      r.backlight_on = backlight_flag;
      r.all_count    = prc_pkg::OUT_COUNT_W'(total_lifts);
      r.day_count    = prc_pkg::OUT_COUNT_W'(daily_lifts);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("[%0t] %s", $time, what);
   endtask

   task automatic queue_beat(input logic kind, input logic [prc_pkg::TIME_W-1:0] at_ms,
                             input logic [prc_pkg::ECHO_W-1:0] echo,
                             input logic [prc_pkg::YEAR_W-1:0] y,
                             input logic [prc_pkg::MONTH_W-1:0] m,
                             input logic [prc_pkg::DAY_W-1:0] d);
      sensor_beat_type b;
      b.req_type = kind;
      b.now_ms   = at_ms;
      b.echo_us  = echo;
      b.year     = y;
      b.month    = m;
      b.day      = d;
      pending_beats.push_back(b);
   endtask

   function automatic logic [prc_pkg::ECHO_W-1:0] echo_for_cm(input int unsigned cm);
      int unsigned us;
      us = cm * 58 + $urandom_range(0, 57);
      if (us > 32'hFFFFF) us = 32'hFFFFF;
      return us[prc_pkg::ECHO_W-1:0];
   endfunction

   task automatic queue_sample_cm(input int unsigned cm);
      int unsigned gap_ms;
      // One sample in four is planned no more than one interval after the previous item.
      if ($urandom_range(0, 3) == 0) gap_ms = $urandom_range(0, lift_cfg.sample_interval);
      else gap_ms = lift_cfg.sample_interval + $urandom_range(1, 400);
      plan_ms = plan_ms + gap_ms;
      queue_beat(prc_pkg::REQ_SAMPLE, plan_ms, echo_for_cm(cm), 8'($urandom), 4'($urandom),
                 5'($urandom));
   endtask

   task automatic queue_random_phase(input int count);
      int made;
      int pick;
      int run;
      int unsigned cm;
      int unsigned lift_cm;
      int unsigned empty_cm;
      made = 0;
      while (made < count) begin
         lift_cm  = lift_cfg.lift_limit;
         empty_cm = lift_cfg.near_limit;
         pick     = $urandom_range(0, 99);
         if (pick < 85) begin
            run = (pick < 45) ? $urandom_range(2, 8) : $urandom_range(1, 4);
            repeat (run) begin
               if (pick < 45)
                  cm = (lift_cm > 0) ? $urandom_range(0, lift_cm - 1) : 0;
               else if (pick < 70 && empty_cm > lift_cm + 1)
                  cm = $urandom_range(lift_cm + 1, empty_cm - 1);
               else if (pick < 80)
                  cm = $urandom_range(empty_cm + 1, 18000);
               else
                  cm = $urandom_range(0, 1) ? lift_cm : empty_cm;
               queue_sample_cm(cm);
               made++;
            end
         end else if (pick < 91) begin
            if ($urandom_range(0, 1)) begin
               plan_year  = 8'($urandom);
               plan_month = 4'($urandom);
               plan_day   = 5'($urandom);
            end
            queue_beat(prc_pkg::REQ_DATE, plan_ms, 20'($urandom), plan_year, plan_month,
                       plan_day);
            made++;
         end else if (pick < 95) begin
            // Jump close to the top of the timer, or back in time.
            if ($urandom_range(0, 1)) plan_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            else plan_ms = $urandom_range(0, plan_ms);
            queue_sample_cm((lift_cm > 0) ? $urandom_range(0, lift_cm - 1) : 0);
            made++;
         end else begin
            queue_beat(1'($urandom), $urandom, 20'($urandom), 8'($urandom), 4'($urandom),
                       5'($urandom));
            made++;
         end
      end
   endtask

   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_ch.valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(input logic [prc_pkg::CSR_IDX_W-1:0] idx,
                                input logic [prc_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         prc_pkg::CSR_NEAR_LIMIT:
            lift_cfg.near_limit = value[prc_pkg::DISTCFG_W-1:0];
         prc_pkg::CSR_LIFT_LIMIT:
            lift_cfg.lift_limit = value[prc_pkg::DISTCFG_W-1:0];
         prc_pkg::CSR_ON_DELAY:        lift_cfg.backlight_on_delay  = value;
         prc_pkg::CSR_OFF_DELAY:       lift_cfg.backlight_off_delay = value;
         prc_pkg::CSR_DWELL_TIME:      lift_cfg.dwell_time          = value;
         prc_pkg::CSR_REFRACTORY_TIME: lift_cfg.refractory_time     = value;
         prc_pkg::CSR_SAMPLE_INTERVAL: lift_cfg.sample_interval     = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_settings(input logic [prc_pkg::CSR_DATA_W-1:0] empty_cm, lifting_cm,
                                 on_ms, off_ms, dwell_ms, refractory_ms, interval_ms);
      write_setting(prc_pkg::CSR_NEAR_LIMIT, empty_cm);
      write_setting(prc_pkg::CSR_LIFT_LIMIT, lifting_cm);
      write_setting(prc_pkg::CSR_ON_DELAY, on_ms);
      write_setting(prc_pkg::CSR_OFF_DELAY, off_ms);
      write_setting(prc_pkg::CSR_DWELL_TIME, dwell_ms);
      write_setting(prc_pkg::CSR_REFRACTORY_TIME, refractory_ms);
      write_setting(prc_pkg::CSR_SAMPLE_INTERVAL, interval_ms);
   endtask

   always @(posedge clock) begin : drive_requests
      logic holding;
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(predict_lift_result(held_beat));
         holding    = req_ch.valid && !req_ch.ready;
         next_valid = holding;
         if (!holding) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 14);
            end else if (pending_beats.size() != 0) begin
               held_beat        = pending_beats.pop_front();
               req_ch.req_type <= held_beat.req_type;
               req_ch.now_ms   <= held_beat.now_ms;
               req_ch.echo_us  <= held_beat.echo_us;
               req_ch.year     <= held_beat.year;
               req_ch.month    <= held_beat.month;
               req_ch.day      <= held_beat.day;
               next_valid       = 1'b1;
            end
         end
         req_ch.valid <= next_valid;
      end
   end

   always @(posedge clock) begin : check_responses
      prc_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response beat with no item outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.backlight_on !== want.backlight_on)
               report_mismatch($sformatf("backlight_on %b, expected %b",
                                         rsp_ch.backlight_on, want.backlight_on));
            if (rsp_ch.counted !== want.counted)
               report_mismatch($sformatf("counted %b, expected %b",
                                         rsp_ch.counted, want.counted));
            if (rsp_ch.all_count !== want.all_count)
               report_mismatch($sformatf("all_count %0d, expected %0d",
                                         rsp_ch.all_count, want.all_count));
            if (rsp_ch.day_count !== want.day_count)
               report_mismatch($sformatf("day_count %0d, expected %0d",
                                         rsp_ch.day_count, want.day_count));
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!reset && idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      idling_on       = 1'b1;
      send_gap        = 0;
      stall_left      = 0;
      mismatch_count  = 0;
      req_ch.valid    = 1'b0;
      req_ch.req_type = prc_pkg::REQ_SAMPLE;
      req_ch.now_ms   = '0;
      req_ch.echo_us  = '0;
      req_ch.year     = '0;
      req_ch.month    = '0;
      req_ch.day      = '0;
      rsp_ch.ready    = 1'b1;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = prc_pkg::CSR_NEAR_LIMIT;
      csr_ch.data     = '0;

      lift_cfg.near_limit          = 12'd100;
      lift_cfg.lift_limit          = 12'd30;
      lift_cfg.backlight_on_delay  = 16'd500;
      lift_cfg.backlight_off_delay = 16'd10000;
      lift_cfg.dwell_time          = 16'd1000;
      lift_cfg.refractory_time     = 16'd2000;
      lift_cfg.sample_interval     = 16'd100;
      last_sample_ms = '0;
      last_near_ms   = '0;
      last_empty_ms  = '0;
      last_count_ms  = '0;
      lift_start_ms  = '0;
      lift_done      = 1'b0;
      backlight_flag = 1'b1;
      total_lifts    = '0;
      daily_lifts    = '0;
      date_year      = '0;
      date_month     = '0;
      date_day       = '0;
      plan_ms        = '0;
      plan_year      = '0;
      plan_month     = '0;
      plan_day       = '0;

      // Directed items under the reset settings. The block waits for reset.
      queue_beat(prc_pkg::REQ_DATE,   32'd0,     20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd0,     20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd50,    20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd101,   20'd57,    8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd1300,  20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd2101,  20'd1739,  8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd2300,  20'd1739,  8'd0,   4'd0,  5'd0);
      // Distances that sit exactly on the lifting and the empty threshold.
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd2500,  20'd1740,  8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd2700,  20'd5800,  8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd2900,  20'd5857,  8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd13000, 20'hFFFFF, 8'hFF,  4'hF,  5'h1F);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd13200, 20'd6000,  8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd13900, 20'd3000,  8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_DATE,   32'd14000, 20'd0,     8'd255, 4'd15, 5'd31);
      queue_beat(prc_pkg::REQ_DATE,   32'd14000, 20'hFFFFF, 8'd255, 4'd15, 5'd31);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd14200, 20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd16500, 20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_DATE,   32'd16600, 20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd5,     20'd0,     8'd0,   4'd0,  5'd0);
      // Near the top of the timer the interval sum wraps.
      queue_beat(prc_pkg::REQ_SAMPLE, 32'hFFFF_FFF0, 20'd1000000, 8'd0, 4'd0, 5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'hFFFF_FFFF, 20'd0,       8'd0, 4'd0, 5'd0);
      queue_beat(prc_pkg::REQ_DATE,   32'hFFFF_FFFF, 20'd0,       8'd1, 4'd12, 5'd1);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd0,     20'd0,     8'd0,   4'd0,  5'd0);
      queue_beat(prc_pkg::REQ_SAMPLE, 32'd120,   20'd0,     8'd0,   4'd0,  5'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_for_idle();

      plan_ms = 32'd1000;
      write_setting(CSR_SPARE_INDEX, 16'hA5A5);
      write_settings(16'd120, 16'd40, 16'd300, 16'd1500, 16'd400, 16'd800, 16'd50);
      queue_random_phase(180);
      wait_for_idle();

      write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_random_phase(110);
      wait_for_idle();

      // All ones: the distance registers keep only their low 12 bits.
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_random_phase(110);
      wait_for_idle();

      write_settings(16'($urandom_range(1, 200)), 16'($urandom_range(0, 60)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 1500)), 16'($urandom_range(0, 2500)),
                     16'($urandom_range(0, 200)));
      queue_random_phase(150);
      wait_for_idle();

      idling_on <= 1'b0;
      write_settings(16'd100, 16'd30, 16'd200, 16'd1000, 16'd300, 16'd500, 16'd20);
      queue_random_phase(150);
      wait_for_idle();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/prc_pkg.sv
rtl/prc_if.sv
rtl/prc_csr.sv
rtl/prc_core.sv
rtl/proximity_rep_counter.sv
sim/tb_proximity_rep_counter.sv
